@@ src/rfd_pkg.sv @@
// Shared types and constants for the response frame deframer.
package rfd_pkg;

   localparam int unsigned BUFFER_BYTES = 64;

   localparam logic [7:0] RDY_BYTE = 8'h01;
   localparam logic [7:0] PRE_BYTE = 8'h00;
   localparam logic [7:0] SC1_BYTE = 8'h00;
   localparam logic [7:0] SC2_BYTE = 8'hFF;
   localparam logic [7:0] DIR_BYTE = 8'hD5;
   localparam logic [7:0] STAT_OK  = 8'h00;

   localparam logic [8:0] OVERHEAD_PLAIN  = 9'd2;
   localparam logic [8:0] OVERHEAD_STATUS = 9'd3;
   localparam logic [8:0] BUFFER_LIMIT    = 9'(BUFFER_BYTES);

   localparam logic [3:0] ERR_OK        = 4'd0;
   localparam logic [3:0] ERR_NOT_READY = 4'd1;
   localparam logic [3:0] ERR_HEADER    = 4'd2;
   localparam logic [3:0] ERR_LEN_CSUM  = 4'd3;
   localparam logic [3:0] ERR_LEN_RANGE = 4'd4;
   localparam logic [3:0] ERR_DIRECTION = 4'd5;
   localparam logic [3:0] ERR_CODE      = 4'd6;
   localparam logic [3:0] ERR_STATUS    = 4'd7;
   localparam logic [3:0] ERR_DATA_CSUM = 4'd8;

   localparam logic REG_EXPECTED_COMMAND = 1'b0;
   localparam logic REG_HAS_STATUS_BYTE  = 1'b1;

   typedef struct packed {
      logic [7:0] expected_command;
      logic       has_status_byte;
   } cfg_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_data;
      logic       is_last;
      logic [3:0] error_code;
      logic [6:0] payload_length;
   } result_type;

endpackage

@@ src/rfd_csr.sv @@
// Configuration registers behind the APB-style port.
module rfd_csr import rfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_EXPECTED_COMMAND: cfg_in.expected_command = csr_pwdata[7:0];
            REG_HAS_STATUS_BYTE:  cfg_in.has_status_byte  = csr_pwdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_EXPECTED_COMMAND: csr_prdata = {24'd0, cfg_ff.expected_command};
         REG_HAS_STATUS_BYTE:  csr_prdata = {31'd0, cfg_ff.has_status_byte};
         default:              csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ src/rfd_parser.sv @@
// Input register, frame parser state machine and result register.
module rfd_parser import rfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_start,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   localparam logic [3:0] P_IDLE = 4'd0;
   localparam logic [3:0] P_PRE  = 4'd1;
   localparam logic [3:0] P_SC1  = 4'd2;
   localparam logic [3:0] P_SC2  = 4'd3;
   localparam logic [3:0] P_LEN  = 4'd4;
   localparam logic [3:0] P_LCS  = 4'd5;
   localparam logic [3:0] P_DIR  = 4'd6;
   localparam logic [3:0] P_CODE = 4'd7;
   localparam logic [3:0] P_STAT = 4'd8;
   localparam logic [3:0] P_DATA = 4'd9;
   localparam logic [3:0] P_DCS  = 4'd10;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   logic [3:0] pos_ff, pos_in;
   logic [7:0] csum_ff, csum_in;
   logic [6:0] remain_ff, remain_in;
   logic [6:0] announced_ff, announced_in;
   logic [7:0] len_byte_ff, len_byte_in;

   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic       advance;
   logic       emit;
   result_type res;
   logic [7:0] code;
   logic [7:0] csum_add;
   logic [8:0] overhead;
   logic [8:0] len_ext;
   logic [8:0] len_net;
   logic [6:0] remain_dec;
   logic [3:0] after_hdr;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
      end
   end

   assign code       = cfg.expected_command + 8'd1;
   assign csum_add   = csum_ff + in_byte_ff;
   assign overhead   = cfg.has_status_byte ? OVERHEAD_STATUS : OVERHEAD_PLAIN;
   assign len_ext    = {1'b0, len_byte_ff};
   assign len_net    = len_ext - overhead;
   assign remain_dec = (remain_ff != 7'd0) ? remain_ff - 7'd1 : remain_ff;
   assign after_hdr  = (remain_ff != 7'd0) ? P_DATA : P_DCS;

   always_comb begin
      pos_in       = pos_ff;
      csum_in      = csum_ff;
      remain_in    = remain_ff;
      announced_in = announced_ff;
      len_byte_in  = len_byte_ff;
      emit         = 1'b0;
      res          = '0;
      res.payload_length = announced_ff;
      res.is_last  = 1'b1;
      if (in_start_ff) begin
         csum_in      = '0;
         remain_in    = '0;
         announced_in = '0;
         len_byte_in  = '0;
         res.payload_length = '0;
         if (in_byte_ff != RDY_BYTE) begin
            emit           = 1'b1;
            res.error_code = ERR_NOT_READY;
            pos_in         = P_IDLE;
         end else begin
            pos_in = P_PRE;
         end
      end else begin
         unique case (pos_ff)
            P_PRE, P_SC1, P_SC2: begin
               res.payload_length = '0;
               if ((pos_ff == P_PRE && in_byte_ff != PRE_BYTE) ||
                   (pos_ff == P_SC1 && in_byte_ff != SC1_BYTE) ||
                   (pos_ff == P_SC2 && in_byte_ff != SC2_BYTE)) begin
                  emit           = 1'b1;
                  res.error_code = ERR_HEADER;
                  pos_in         = P_IDLE;
               end else begin
                  pos_in = pos_ff + 4'd1;
               end
            end
            P_LEN: begin
               len_byte_in = in_byte_ff;
               pos_in      = P_LCS;
            end
            P_LCS: begin
               res.payload_length = '0;
               if (8'(len_byte_ff + in_byte_ff) != 8'd0) begin
                  emit           = 1'b1;
                  res.error_code = ERR_LEN_CSUM;
                  pos_in         = P_IDLE;
               end else if (len_ext < overhead || len_net > BUFFER_LIMIT) begin
                  emit           = 1'b1;
                  res.error_code = ERR_LEN_RANGE;
                  pos_in         = P_IDLE;
               end else begin
                  announced_in = len_net[6:0];
                  remain_in    = len_net[6:0];
                  pos_in       = P_DIR;
               end
            end
            P_DIR: begin
               if (in_byte_ff != DIR_BYTE) begin
                  emit           = 1'b1;
                  res.error_code = ERR_DIRECTION;
                  pos_in         = P_IDLE;
               end else begin
                  csum_in = in_byte_ff;
                  pos_in  = P_CODE;
               end
            end
            P_CODE: begin
               if (in_byte_ff != code) begin
                  emit           = 1'b1;
                  res.error_code = ERR_CODE;
                  pos_in         = P_IDLE;
               end else begin
                  csum_in = csum_add;
                  pos_in  = cfg.has_status_byte ? P_STAT : after_hdr;
               end
            end
            P_STAT: begin
               if (in_byte_ff != STAT_OK) begin
                  emit           = 1'b1;
                  res.error_code = ERR_STATUS;
                  pos_in         = P_IDLE;
               end else begin
                  pos_in = after_hdr;
               end
            end
            P_DATA: begin
               csum_in          = csum_add;
               remain_in        = remain_dec;
               pos_in           = (remain_dec == 7'd0) ? P_DCS : P_DATA;
               emit             = 1'b1;
               res.payload_byte = in_byte_ff;
               res.is_data      = 1'b1;
               res.is_last      = 1'b0;
            end
            P_DCS: begin
               csum_in        = csum_add;
               emit           = 1'b1;
               res.error_code = (csum_add == 8'd0) ? ERR_OK : ERR_DATA_CSUM;
               pos_in         = P_IDLE;
            end
            default: begin
               pos_in = P_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= P_IDLE;
         csum_ff      <= '0;
         remain_ff    <= '0;
         announced_ff <= '0;
         len_byte_ff  <= '0;
      end else if (advance) begin
         pos_ff       <= pos_in;
         csum_ff      <= csum_in;
         remain_ff    <= remain_in;
         announced_ff <= announced_in;
         len_byte_ff  <= len_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_data_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.is_data != rsp_ff.is_last))
      else $error("data word flagged as last");

   a_data_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.is_data) |-> (rsp_ff.error_code == ERR_OK))
      else $error("data word carries an error code");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({2'b00, rsp_ff.payload_length} <= BUFFER_LIMIT))
      else $error("payload length beyond buffer");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result word lost");

   a_data_remaining: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == P_DATA) |-> (remain_ff != 7'd0))
      else $error("data state with no bytes remaining");

endmodule

@@ src/response_frame_deframer.sv @@
// Top level of the response frame deframer.
// An accepted word enters the input register; any result word is then registered.
// Throughput: one input word per cycle, set by the single-pass parser between
// the input register and the result register; a stalled result holds the input side.
// Reset (synchronous, active high) returns the parser to idle, clears the result
// register valid and sets both configuration registers to zero.
module response_frame_deframer import rfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_is_data,
   output logic        rsp_is_last,
   output logic [3:0]  rsp_error_code,
   output logic [6:0]  rsp_payload_length,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg;
   result_type rsp;

   rfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rfd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp             (rsp)
   );

   assign rsp_payload_byte   = rsp.payload_byte;
   assign rsp_is_data        = rsp.is_data;
   assign rsp_is_last        = rsp.is_last;
   assign rsp_error_code     = rsp.error_code;
   assign rsp_payload_length = rsp.payload_length;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the response frame deframer.
`timescale 1ns / 1ps

module testbench;
   import rfd_pkg::*;

   localparam int LATENCY_CYCLES = 2;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_WORDS   = 1550;
   localparam int CONFIG_PHASES  = 10;

   typedef enum logic [3:0] {
      PS_IDLE, PS_PREAMBLE, PS_START1, PS_START2, PS_LENGTH, PS_LENGTH_CSUM,
      PS_DIRECTION, PS_CODE, PS_STATUS, PS_DATA, PS_DATA_CSUM
   } parse_pos_type;

   typedef enum int {
      FAULT_NONE, FAULT_READY, FAULT_HEADER, FAULT_LEN_CSUM, FAULT_LEN_RANGE,
      FAULT_DIRECTION, FAULT_CODE, FAULT_STATUS, FAULT_DATA_CSUM, FAULT_CUT
   } frame_fault_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte        = 8'h00;
   logic        req_frame_start    = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_is_data;
   logic        rsp_is_last;
   logic [3:0]  rsp_error_code;
   logic [6:0]  rsp_payload_length;
   logic        csr_psel           = 1'b0;
   logic        csr_penable        = 1'b0;
   logic        csr_pwrite         = 1'b0;
   logic [2:0]  csr_paddr          = 3'd0;
   logic [31:0] csr_pwdata         = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   response_frame_deframer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_is_data        (rsp_is_data),
      .rsp_is_last        (rsp_is_last),
      .rsp_error_code     (rsp_error_code),
      .rsp_payload_length (rsp_payload_length),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #1 clock = ~clock;

   // parser shadow
   cfg_type       cfg_shadow = '0;
   parse_pos_type frame_pos  = PS_IDLE;
   logic [7:0]    frame_csum = 8'd0;
   logic [6:0]    bytes_left = 7'd0;
   logic [6:0]    frame_len  = 7'd0;
   logic [7:0]    len_field  = 8'd0;

   result_type pending_words[$];

   int sent_words     = 0;
   int burst_left     = 0;
   int mismatches     = 0;
   int results_seen   = 0;
   int payload_seen   = 0;
   int endings_seen[16];
   int hold_left      = 0;
   bit hold_request   = 1'b0;
   int stall_left     = 0;
   int stall_pct      = 0;

   function automatic logic [7:0] flip_mask();
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic void report_mismatch(input string what, input result_type want,
                                           input result_type got);
      mismatches++;
      if (mismatches <= 10)
         $display({"%s: expected byte %h data %b last %b err %0d len %0d, ",
                   "got byte %h data %b last %b err %0d len %0d"},
                  what, want.payload_byte, want.is_data, want.is_last, want.error_code,
                  want.payload_length, got.payload_byte, got.is_data, got.is_last,
                  got.error_code, got.payload_length);
   endfunction

   function automatic void close_frame(input logic [3:0] code, input logic [6:0] len);
      result_type r;
      r.payload_byte   = 8'd0;
      r.is_data        = 1'b0;
      r.is_last        = 1'b1;
      r.error_code     = code;
      r.payload_length = len;
      frame_pos = PS_IDLE;
      pending_words.push_back(r);
   endfunction

   function automatic void deframe_word(input logic [7:0] rx, input logic start);
      result_type r;
      logic [7:0] code;
      logic [8:0] overhead;
      logic [8:0] ext_len;
      code = cfg_shadow.expected_command + 8'd1;
      if (start) begin
         frame_csum = 8'd0;
         bytes_left = 7'd0;
         frame_len  = 7'd0;
         len_field  = 8'd0;
         if (rx != RDY_BYTE) close_frame(ERR_NOT_READY, 7'd0);
         else frame_pos = PS_PREAMBLE;
      end else begin
         case (frame_pos)
            PS_PREAMBLE: begin
               if (rx != PRE_BYTE) close_frame(ERR_HEADER, 7'd0);
               else frame_pos = PS_START1;
            end
            PS_START1: begin
               if (rx != SC1_BYTE) close_frame(ERR_HEADER, 7'd0);
               else frame_pos = PS_START2;
            end
            PS_START2: begin
               if (rx != SC2_BYTE) close_frame(ERR_HEADER, 7'd0);
               else frame_pos = PS_LENGTH;
            end
            PS_LENGTH: begin
               len_field = rx;
               frame_pos = PS_LENGTH_CSUM;
            end
            PS_LENGTH_CSUM: begin
               overhead = cfg_shadow.has_status_byte ? OVERHEAD_STATUS : OVERHEAD_PLAIN;
               ext_len  = {1'b0, len_field};
               if (8'(len_field + rx) != 8'd0) close_frame(ERR_LEN_CSUM, 7'd0);
               else if (ext_len < overhead || ext_len - overhead > BUFFER_LIMIT)
                  close_frame(ERR_LEN_RANGE, 7'd0);
               else begin
                  frame_len  = 7'(ext_len - overhead);
                  bytes_left = frame_len;
                  frame_pos  = PS_DIRECTION;
               end
            end
            PS_DIRECTION: begin
               if (rx != DIR_BYTE) close_frame(ERR_DIRECTION, frame_len);
               else begin
                  frame_csum = rx;
                  frame_pos  = PS_CODE;
               end
            end
            PS_CODE: begin
               if (rx != code) close_frame(ERR_CODE, frame_len);
               else begin
                  frame_csum = frame_csum + rx;
                  if (cfg_shadow.has_status_byte) frame_pos = PS_STATUS;
                  else frame_pos = (bytes_left != 0) ? PS_DATA : PS_DATA_CSUM;
               end
            end
            PS_STATUS: begin
               if (rx != STAT_OK) close_frame(ERR_STATUS, frame_len);
               else frame_pos = (bytes_left != 0) ? PS_DATA : PS_DATA_CSUM;
            end
            PS_DATA: begin
               frame_csum = frame_csum + rx;
               if (bytes_left != 0) bytes_left--;
               if (bytes_left == 0) frame_pos = PS_DATA_CSUM;
               r.payload_byte   = rx;
               r.is_data        = 1'b1;
               r.is_last        = 1'b0;
               r.error_code     = ERR_OK;
               r.payload_length = frame_len;
               pending_words.push_back(r);
            end
            PS_DATA_CSUM: begin
               frame_csum = frame_csum + rx;
               close_frame((frame_csum == 8'd0) ? ERR_OK : ERR_DATA_CSUM, frame_len);
            end
            default: frame_pos = PS_IDLE;
         endcase
      end
   endfunction

   task automatic send_word(input logic [7:0] rx, input logic start);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
         gap = 0;
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= rx;
      req_frame_start <= start;
      do @(posedge clock); while (!req_ready);
      deframe_word(rx, start);
      sent_words++;
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (LATENCY_CYCLES + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] field;
      quiesce();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == REG_EXPECTED_COMMAND) begin
         cfg_shadow.expected_command = value[7:0];
         field = 32'(value[7:0]);
      end else begin
         cfg_shadow.has_status_byte = value[0];
         field = 32'(value[0]);
      end
      if (readback !== field) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register %0d readback: expected %h, got %h", idx, field, readback);
      end
   endtask

   task automatic send_frame(input int plen, input frame_fault_type fault);
      logic [7:0] bytes[$];
      logic [7:0] code;
      logic [7:0] len;
      logic [7:0] sum;
      logic [7:0] b;
      int overhead;
      int cut;
      int idx;
      overhead = cfg_shadow.has_status_byte ? int'(OVERHEAD_STATUS) : int'(OVERHEAD_PLAIN);
      code = cfg_shadow.expected_command + 8'd1;
      len  = 8'(plen + overhead);
      bytes.push_back(RDY_BYTE);
      bytes.push_back(PRE_BYTE);
      bytes.push_back(SC1_BYTE);
      bytes.push_back(SC2_BYTE);
      bytes.push_back(len);
      bytes.push_back(8'(0 - len));
      bytes.push_back(DIR_BYTE);
      bytes.push_back(code);
      sum = DIR_BYTE + code;
      if (cfg_shadow.has_status_byte) bytes.push_back(STAT_OK);
      for (int i = 0; i < plen; i++) begin
         b = 8'($urandom);
         sum = sum + b;
         bytes.push_back(b);
      end
      bytes.push_back(8'(0 - sum));
      case (fault)
         FAULT_READY: begin
            do bytes[0] = 8'($urandom); while (bytes[0] == RDY_BYTE);
         end
         FAULT_HEADER: begin
            idx = $urandom_range(1, 3);
            bytes[idx] = bytes[idx] ^ flip_mask();
         end
         FAULT_LEN_CSUM: bytes[5] = bytes[5] ^ flip_mask();
         FAULT_LEN_RANGE: begin
            if ($urandom_range(0, 1) == 0) len = 8'($urandom_range(0, overhead - 1));
            else len = 8'($urandom_range(BUFFER_BYTES + overhead + 1, 255));
            bytes[4] = len;
            bytes[5] = 8'(0 - len);
         end
         FAULT_DIRECTION: bytes[6] = bytes[6] ^ flip_mask();
         FAULT_CODE: bytes[7] = bytes[7] ^ flip_mask();
         FAULT_STATUS: begin
            if (cfg_shadow.has_status_byte) bytes[8] = bytes[8] ^ flip_mask();
            else bytes[bytes.size() - 1] = bytes[bytes.size() - 1] ^ flip_mask();
         end
         FAULT_DATA_CSUM: bytes[bytes.size() - 1] = bytes[bytes.size() - 1] ^ flip_mask();
         FAULT_CUT: begin
            cut = $urandom_range(1, bytes.size() - 1);
            while (bytes.size() > cut) void'(bytes.pop_back());
         end
         default: ;
      endcase
      foreach (bytes[i]) send_word(bytes[i], i == 0);
   endtask

   function automatic int pick_length();
      case ($urandom_range(0, 15))
         0:       return BUFFER_BYTES;
         1, 2:    return $urandom_range(9, BUFFER_BYTES);
         default: return $urandom_range(0, 8);
      endcase
   endfunction

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES - 1;
         rsp_ready   <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_left = $urandom_range(8, 64);
            case ($urandom_range(0, 4))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 30;
               3:       stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end
         stall_left--;
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.payload_byte   = rsp_payload_byte;
         got.is_data        = rsp_is_data;
         got.is_last        = rsp_is_last;
         got.error_code     = rsp_error_code;
         got.payload_length = rsp_payload_length;
         results_seen++;
         if (got.is_data === 1'b1) payload_seen++;
         else if (got.is_last === 1'b1 && !$isunknown(got.error_code))
            endings_seen[got.error_code]++;
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
         end else begin
            want = pending_words.pop_front();
            if (got !== want) report_mismatch("result mismatch", want, got);
         end
      end
   end

   task automatic test_outside_bytes();
      send_word(8'hA5, 1'b0);
      send_word(8'hFF, 1'b1);
   endtask

   task automatic test_restart_short_length();
      send_word(RDY_BYTE, 1'b1);
      send_word(PRE_BYTE, 1'b0);
      send_word(SC1_BYTE, 1'b0);
      send_word(RDY_BYTE, 1'b1);
      send_word(PRE_BYTE, 1'b0);
      send_word(SC1_BYTE, 1'b0);
      send_word(SC2_BYTE, 1'b0);
      send_word(8'h01, 1'b0);
      send_word(8'hFF, 1'b0);
   endtask

   task automatic test_command_wrap();
      write_reg(REG_EXPECTED_COMMAND, 32'd255);
      send_frame(0, FAULT_NONE);
   endtask

   task automatic test_status_switch();
      logic [7:0] code;
      code = cfg_shadow.expected_command + 8'd1;
      send_word(RDY_BYTE, 1'b1);
      send_word(PRE_BYTE, 1'b0);
      send_word(SC1_BYTE, 1'b0);
      send_word(SC2_BYTE, 1'b0);
      send_word(8'd5, 1'b0);
      write_reg(REG_HAS_STATUS_BYTE, 32'd1);
      send_word(8'hFB, 1'b0);
      send_word(DIR_BYTE, 1'b0);
      write_reg(REG_HAS_STATUS_BYTE, 32'd0);
      send_word(code, 1'b0);
      send_word(8'h5A, 1'b0);
      send_word(8'hC3, 1'b0);
      send_word(8'(0 - (DIR_BYTE + code + 8'h5A + 8'hC3)), 1'b0);
   endtask

   task automatic test_backpressure();
      write_reg(REG_EXPECTED_COMMAND, 32'($urandom_range(0, 254)));
      write_reg(REG_HAS_STATUS_BYTE, 32'($urandom_range(0, 1)));
      hold_request = 1'b1;
      repeat (4) send_frame(16, FAULT_NONE);
      quiesce();
   endtask

   task automatic test_random_traffic();
      int per_phase;
      int first;
      int pick;
      logic [7:0] cmd;
      logic stat;
      per_phase = RANDOM_WORDS / CONFIG_PHASES;
      for (int phase = 0; phase < CONFIG_PHASES; phase++) begin
         case (phase)
            0: begin cmd = 8'd0;   stat = 1'b0; end
            1: begin cmd = 8'd254; stat = 1'b1; end
            2: begin cmd = 8'd255; stat = 1'b0; end
            3: begin cmd = 8'd0;   stat = 1'b1; end
            default: begin
               cmd  = 8'($urandom_range(0, 255));
               stat = 1'($urandom_range(0, 1));
            end
         endcase
         write_reg(REG_EXPECTED_COMMAND, 32'(cmd));
         write_reg(REG_HAS_STATUS_BYTE, 32'(stat));
         first = sent_words;
         while (sent_words - first < per_phase) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) send_frame(pick_length(), FAULT_NONE);
            else if (pick < 85)
               send_frame(pick_length(),
                          frame_fault_type'($urandom_range(FAULT_READY, FAULT_DATA_CSUM)));
            else if (pick < 93) send_frame(pick_length(), FAULT_CUT);
            else
               repeat ($urandom_range(1, 4))
                  send_word(8'($urandom), ($urandom_range(0, 3) == 0));
         end
      end
   endtask

   initial begin
      foreach (endings_seen[i]) endings_seen[i] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_outside_bytes();
      test_restart_short_length();
      test_command_wrap();
      test_status_switch();
      test_backpressure();
      test_random_traffic();
      quiesce();
      $display("run covered %0d input words, %0d results: %0d payload bytes, %0d endings",
               sent_words, results_seen, payload_seen, results_seen - payload_seen);
      $display("frame endings by code 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
               endings_seen[0], endings_seen[1], endings_seen[2], endings_seen[3],
               endings_seen[4], endings_seen[5], endings_seen[6], endings_seen[7],
               endings_seen[8]);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
